>>> rtl/tvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tvp_pkg;

  // Default number of fraction bits of all fixed-point values
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_POS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_VEL = 3'd5;

  // Register reset values
  localparam logic [31:0] END_TIME_RST   = 32'd65536;
  localparam logic [31:0] BLEND_TIME_RST = 32'd16384;

  // Saturation limits
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Profile phase codes
  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2
  } phase_e;

  // Acceleration output selection
  typedef enum logic [1:0] {
    ACC_POS,
    ACC_ZERO,
    ACC_NEG
  } acc_sel_e;

  // Sequencer that derives cruise velocity, acceleration and blend-end position
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LOAD_V0,
    SEQ_DIV_V0,
    SEQ_CLAMP,
    SEQ_DIV_A,
    SEQ_MUL1,
    SEQ_MUL2,
    SEQ_PTA
  } seq_state_e;

endpackage

`default_nettype wire

>>> rtl/trapezoid_velocity_profile_eval.sv
// Throughput: one sample per cycle while no recompute runs; ready stages let bubbles close
// under output backpressure. Every configuration write starts a recompute of cruise
// velocity, acceleration and the blend-end position, which uses the bit-serial divider; during
// it no sample is taken. Reset loads the register defaults with consistent derived values.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_velocity_profile_eval #(
  parameter int unsigned FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tvp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [31:0]                    sample_time_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [31:0]                  position_o,
  output logic signed [31:0]                  velocity_o,
  output logic signed [31:0]                  acceleration_o,
  output logic [1:0]                          phase_o
);
  import tvp_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned NW = 32 + F;            // divider dividend / quotient width
  localparam int unsigned PW = 64 - F;            // shifted product width
  localparam int unsigned SW = (PW > NW) ? PW : NW;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam int unsigned TW = 35;                // signed time arithmetic width

  // Saturate a magnitude with a sign to 32 bits signed
  function automatic logic signed [31:0] sat_mag(input logic [SW-1:0] m, input logic neg);
    logic hi;
    logic signed [31:0] r;
    hi = |m[SW-1:31];
    if (neg) begin
      r = hi ? S32_MIN : -$signed({1'b0, m[30:0]});
    end else begin
      r = (hi || (&m[30:0])) ? S32_MAX : $signed({1'b0, m[30:0]});
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // ---------------------------------------------------------------- registers
  logic signed [31:0] q1_q, q2_q, vcr_q;
  logic [31:0]        t1_q, t2_q, tau_q;
  logic               cfg_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_req     = cfg_valid_i;

  // Write the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q  <= '0;
      q2_q  <= '0;
      t1_q  <= '0;
      t2_q  <= END_TIME_RST;
      tau_q <= BLEND_TIME_RST;
      vcr_q <= '0;
    end else if (cfg_req) begin
      case (cfg_index_i)
        REG_START_POS:  q1_q  <= $signed(cfg_data_i);
        REG_END_POS:    q2_q  <= $signed(cfg_data_i);
        REG_START_TIME: t1_q  <= cfg_data_i;
        REG_END_TIME:   t2_q  <= cfg_data_i;
        REG_BLEND_TIME: tau_q <= cfg_data_i;
        REG_CRUISE_VEL: vcr_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic [31:0] t2e, taue;
  assign t2e  = (t2_q  == '0) ? 32'd1 : t2_q;
  assign taue = (tau_q == '0) ? 32'd1 : tau_q;

  // ---------------------------------------------------------------- sequencer
  seq_state_e seq_q, seq_d;
  logic [NW-1:0]      div_num_q;
  logic [32:0]        div_rem_q;
  logic [31:0]        div_d_q;
  logic [CW-1:0]      div_cnt_q;
  logic               div_neg_q;
  logic signed [31:0] vc_q, a_q, pta_q, p1_q, p2_q;
  logic               busy;

  // Divider step
  logic [32:0]   rem_sh, rem_nx;
  logic          rem_ge;
  logic [NW-1:0] num_nx;
  logic          div_done;

  assign rem_sh   = {div_rem_q[31:0], div_num_q[NW-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_d_q};
  assign rem_nx   = rem_ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;
  assign num_nx   = {div_num_q[NW-2:0], rem_ge};
  assign div_done = (div_cnt_q == CW'(1));

  // Clamp of the requested cruise velocity against the v0 band
  logic signed [32:0]    dq;
  logic [NW-1:0]         dq_num;
  logic signed [NW+2:0]  v0, v0x2, vcx;
  logic                  vc_bad;
  logic signed [31:0]    vc_new;

  assign dq     = 33'(q2_q) - 33'(q1_q);
  assign dq_num = NW'(dq[32] ? 33'(-dq) : 33'(dq)) << F;
  assign v0     = div_neg_q ? -$signed({3'b000, div_num_q}) : $signed({3'b000, div_num_q});
  assign v0x2   = v0 <<< 1;
  assign vcx    = (NW+3)'(vcr_q);
  assign vc_bad = (q1_q <= q2_q) ? ((vcx < v0) || (vcx > v0x2))
                                 : ((vcx < v0x2) || (vcx > v0));
  assign vc_new = vc_bad ? sat_mag(SW'(div_num_q), div_neg_q) : vcr_q;

  // Acceleration as it leaves the divider
  logic signed [31:0] a_new;
  assign a_new = sat_mag(SW'(div_num_q), div_neg_q);

  // Shared config multiplier: mulq(x, tau)
  logic signed [31:0] mx;
  logic [63:0]        mprod;
  logic signed [31:0] mres;
  logic signed [33:0] pta_sum;
  logic signed [31:0] p2_half;

  assign mx      = (seq_q == SEQ_MUL1) ? a_new : p1_q;
  assign mprod   = 64'(abs32(mx)) * 64'(taue);
  assign mres    = sat_mag(SW'(mprod[63:F]), mx[31]);
  assign p2_half = $signed(p2_q + 32'(p2_q[31])) >>> 1;
  assign pta_sum = 34'(q1_q) + 34'(p2_half);

  // Next state
  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE:    seq_d = SEQ_IDLE;
      SEQ_LOAD_V0: seq_d = SEQ_DIV_V0;
      SEQ_DIV_V0:  if (div_done) seq_d = SEQ_CLAMP;
      SEQ_CLAMP:   seq_d = SEQ_DIV_A;
      SEQ_DIV_A:   if (div_done) seq_d = SEQ_MUL1;
      SEQ_MUL1:    seq_d = SEQ_MUL2;
      SEQ_MUL2:    seq_d = SEQ_PTA;
      SEQ_PTA:     seq_d = SEQ_IDLE;
      default:     seq_d = SEQ_IDLE;
    endcase
    if (cfg_req) seq_d = SEQ_LOAD_V0;
  end

  // Outputs of the sequencer
  always_comb begin
    case (seq_q)
      SEQ_IDLE: busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  // Divider and derived values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q  <= '0;
      a_q   <= '0;
      pta_q <= '0;
    end else begin
      case (seq_q)
        SEQ_CLAMP: vc_q <= vc_new;
        SEQ_MUL1:  a_q  <= a_new;
        SEQ_PTA:   pta_q <= (pta_sum > 34'sd2147483647) ? S32_MAX :
                            (pta_sum < -34'sd2147483648) ? S32_MIN : pta_sum[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (seq_q)
      SEQ_LOAD_V0: begin
        div_num_q <= dq_num;
        div_neg_q <= dq[32];
        div_d_q   <= t2e;
        div_rem_q <= '0;
        div_cnt_q <= CW'(NW);
      end
      SEQ_CLAMP: begin
        div_num_q <= NW'(abs32(vc_new)) << F;
        div_neg_q <= vc_new[31];
        div_d_q   <= taue;
        div_rem_q <= '0;
        div_cnt_q <= CW'(NW);
      end
      SEQ_DIV_V0, SEQ_DIV_A: begin
        div_num_q <= num_nx;
        div_rem_q <= rem_nx;
        div_cnt_q <= div_cnt_q - CW'(1);
      end
      SEQ_MUL1: p1_q <= mres;
      SEQ_MUL2: p2_q <= mres;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic [6:1] v_q;
  logic [6:1] rdy;
  logic       in_req;

  assign rdy[6] = !v_q[6] || out_ready_i;
  assign rdy[5] = !v_q[5] || rdy[6];
  assign rdy[4] = !v_q[4] || rdy[5];
  assign rdy[3] = !v_q[3] || rdy[4];
  assign rdy[2] = !v_q[2] || rdy[3];
  assign rdy[1] = !v_q[1] || rdy[2];

  assign in_ready_o = rdy[1] && !busy;
  assign in_req     = in_valid_i && in_ready_o;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= in_req;
      if (rdy[2]) v_q[2] <= v_q[1];
      if (rdy[3]) v_q[3] <= v_q[2];
      if (rdy[4]) v_q[4] <= v_q[3];
      if (rdy[5]) v_q[5] <= v_q[4];
      if (rdy[6]) v_q[6] <= v_q[5];
    end
  end

  // Stage 1: clamp time into the motion window
  logic [31:0] t_lo, t_cl, s1_t_q;
  assign t_lo = (sample_time_i < t1_q) ? t1_q : sample_time_i;
  assign t_cl = (t_lo > t2_q) ? t2_q : t_lo;

  always_ff @(posedge clk_i) begin
    if (in_req) s1_t_q <= t_cl;
  end

  // Stage 2: phase, acceleration choice, time offset
  logic signed [TW-1:0] ts, t1s, t2s, tas, tds, y;
  logic                 ge_t1, le_ta, lt_ta, gt_ta, ge_ta, le_td, lt_td;
  phase_e               ph2;
  acc_sel_e             as2;
  phase_e               s2_ph_q;
  acc_sel_e             s2_as_q;
  logic [31:0]          s2_ym_q;
  logic                 s2_yn_q;

  assign ts  = TW'({1'b0, s1_t_q});
  assign t1s = TW'({1'b0, t1_q});
  assign t2s = TW'({1'b0, t2_q});
  assign tas = t1s + TW'({1'b0, taue});
  assign tds = t2s - TW'({1'b0, taue});
  assign ge_t1 = ts >= t1s;
  assign le_ta = ts <= tas;
  assign lt_ta = ts <  tas;
  assign gt_ta = ts >  tas;
  assign ge_ta = ts >= tas;
  assign le_td = ts <= tds;
  assign lt_td = ts <  tds;

  always_comb begin
    if (ge_t1 && le_ta) begin
      ph2 = PH_ACCEL;
      y   = ts - t1s;
    end else if (gt_ta && le_td) begin
      ph2 = PH_CRUISE;
      y   = ts - tas;
    end else begin
      ph2 = PH_DECEL;
      y   = ts - t2s;
    end
    if (ge_t1 && lt_ta)      as2 = ACC_POS;
    else if (ge_ta && lt_td) as2 = ACC_ZERO;
    else                     as2 = ACC_NEG;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      s2_ph_q <= ph2;
      s2_as_q <= as2;
      s2_yn_q <= y[TW-1];
      s2_ym_q <= y[TW-1] ? 32'(-y) : 32'(y);
    end
  end

  // Stage 3: first product |a| * |y|
  phase_e      s3_ph_q;
  acc_sel_e    s3_as_q;
  logic [31:0] s3_ym_q;
  logic        s3_yn_q;
  logic [63:0] s3_prod_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      s3_ph_q   <= s2_ph_q;
      s3_as_q   <= s2_as_q;
      s3_ym_q   <= s2_ym_q;
      s3_yn_q   <= s2_yn_q;
      s3_prod_q <= 64'(abs32(a_q)) * 64'(s2_ym_q);
    end
  end

  // Stage 4: velocity, acceleration, second multiplicand
  logic signed [31:0] m1_v, m1_p, vel4, x24, acc4;
  assign m1_v = sat_mag(SW'(s3_prod_q[63:F]), a_q[31]);
  assign m1_p = sat_mag(SW'(s3_prod_q[63:F]), a_q[31] ^ s3_yn_q);

  always_comb begin
    case (s3_ph_q)
      PH_ACCEL:  begin vel4 = m1_v; x24 = m1_v; end
      PH_CRUISE: begin vel4 = vc_q; x24 = vc_q; end
      default:   begin vel4 = m1_v; x24 = m1_p; end
    endcase
    case (s3_as_q)
      ACC_POS:  acc4 = a_q;
      ACC_ZERO: acc4 = '0;
      default:  acc4 = (a_q == S32_MIN) ? S32_MAX : -a_q;
    endcase
  end

  phase_e             s4_ph_q;
  logic [31:0]        s4_ym_q;
  logic               s4_yn_q;
  logic signed [31:0] s4_vel_q, s4_acc_q, s4_x2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      s4_ph_q  <= s3_ph_q;
      s4_ym_q  <= s3_ym_q;
      s4_yn_q  <= s3_yn_q;
      s4_vel_q <= vel4;
      s4_acc_q <= acc4;
      s4_x2_q  <= x24;
    end
  end

  // Stage 5: second product |x2| * |y|
  phase_e             s5_ph_q;
  logic               s5_neg_q;
  logic [63:0]        s5_prod_q;
  logic signed [31:0] s5_vel_q, s5_acc_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5] && v_q[4]) begin
      s5_ph_q   <= s4_ph_q;
      s5_neg_q  <= s4_x2_q[31] ^ s4_yn_q;
      s5_prod_q <= 64'(abs32(s4_x2_q)) * 64'(s4_ym_q);
      s5_vel_q  <= s4_vel_q;
      s5_acc_q  <= s4_acc_q;
    end
  end

  // Stage 6: position sum into the output register
  logic signed [31:0] m2, m2_half;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos6;

  assign m2      = sat_mag(SW'(s5_prod_q[63:F]), s5_neg_q);
  assign m2_half = $signed(m2 + 32'(m2[31])) >>> 1;

  always_comb begin
    case (s5_ph_q)
      PH_ACCEL:  pos_sum = 34'(q1_q) + 34'(m2_half);
      PH_CRUISE: pos_sum = 34'(pta_q) + 34'(m2);
      default:   pos_sum = 34'(q2_q) - 34'(m2_half);
    endcase
    if (pos_sum > 34'sd2147483647)       pos6 = S32_MAX;
    else if (pos_sum < -34'sd2147483648) pos6 = S32_MIN;
    else                                 pos6 = pos_sum[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6] && v_q[5]) begin
      position_o     <= pos6;
      velocity_o     <= s5_vel_q;
      acceleration_o <= s5_acc_q;
      phase_o        <= s5_ph_q;
    end
  end

  assign out_valid_o = v_q[6];

endmodule

`default_nettype wire

>>> rtl/tvp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tvp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [31:0]            position_o,
  input wire logic signed [31:0]            velocity_o,
  input wire logic signed [31:0]            acceleration_o,
  input wire logic [1:0]                    phase_o
);
  import tvp_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(position_o) && $stable(velocity_o)
                                    && $stable(acceleration_o) && $stable(phase_o))
    else $error("result changed while stalled");

  // A register write starts the recompute, which blocks new samples
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("sample taken during recompute");

  // Phase is always a real code
  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_o == PH_ACCEL) || (phase_o == PH_CRUISE)
                    || (phase_o == PH_DECEL))
    else $error("bad phase code");

endmodule

bind trapezoid_velocity_profile_eval tvp_checker u_tvp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .position_o     (position_o),
  .velocity_o     (velocity_o),
  .acceleration_o (acceleration_o),
  .phase_o        (phase_o)
);

`default_nettype wire
